// ===== rtl/tsr_pkg.sv =====
package tsr_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    // walk position: fill + header + largest length + header
    localparam int POS_W        = $clog2(BUFFER_BYTES + 65542);
    localparam int CUR_W        = 13;

    localparam logic [2:0] MODE_LOAD   = 3'd0;
    localparam logic [2:0] MODE_CLEAR  = 3'd1;
    localparam logic [2:0] MODE_RD16   = 3'd2;
    localparam logic [2:0] MODE_RD32   = 3'd3;
    localparam logic [2:0] MODE_FOURCC = 3'd4;
    localparam logic [2:0] MODE_SKIP   = 3'd5;

    localparam logic [2:0] NEED16 = 3'd2;
    localparam logic [2:0] NEED32 = 3'd4;

endpackage

// ===== rtl/tsr_if.sv =====
interface tsr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [7:0]  data_byte;
    logic [7:0]  tag;
    logic [31:0] fourcc;

    modport source (output valid, mode, data_byte, tag, fourcc, input ready);
    modport sink   (input valid, mode, data_byte, tag, fourcc, output ready);
endinterface

interface tsr_out_if import tsr_pkg::*;;
    logic             valid;
    logic             ready;
    logic [31:0]      value;
    logic             found;
    logic             miss_flag;
    logic [CUR_W-1:0] cursor_pos;
    logic             load_dropped;

    modport source (output valid, value, found, miss_flag, cursor_pos, load_dropped,
                    input ready);
    modport sink   (input valid, value, found, miss_flag, cursor_pos, load_dropped,
                    output ready);
endinterface

// ===== rtl/tlv_tag_seek_reader.sv =====
// channel | port  | dir | payload
// --------+-------+-----+-------------------------------------------------
// input   | i_in  | in  | mode, data_byte, tag, fourcc
// result  | o_out | out | value, found, miss_flag, cursor_pos, load_dropped
//
// Load, clear and unused modes are answered straight from idle, as is a query that misses at once.
// Tag query: a tag, length-high and length-low read per skipped entry, then the match,
// then the 2 or 4 payload byte reads. Fourcc query: one byte read per byte scanned, then 4 reads.
// The steps follow the single read port of the byte store, one byte a cycle.
// Reset is synchronous, active low; the byte store needs no clearing pass.
// A waiting result stalls the next item only until it is taken.
module tlv_tag_seek_reader import tsr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsr_in_if.sink       i_in,
    tsr_out_if.source    o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WTAG  = 3'd1;
    localparam logic [2:0] S_WLEN1 = 3'd2;
    localparam logic [2:0] S_WLEN2 = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_READ  = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_mode, n_mode;
    logic [7:0]       r_tag, n_tag;
    logic [31:0]      r_pattern, n_pattern;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_cursor, n_cursor;
    logic             r_miss, n_miss;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_len_hi, n_len_hi;
    logic [2:0]       r_cnt, n_cnt;
    logic [31:0]      r_acc, n_acc;

    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_out_value, n_out_value;
    logic             r_out_found, n_out_found;
    logic             r_out_miss, n_out_miss;
    logic [CNT_W-1:0] r_out_cursor, n_out_cursor;
    logic             r_out_dropped, n_out_dropped;

    logic              in_ready;
    logic              ram_we;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        ram_q;

    tsr_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[ADDR_W-1:0]),
        .i_wdata (i_in.data_byte),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        logic             acc;
        logic             fin;
        logic             fin_found;
        logic             fin_miss;
        logic             fin_drop;
        logic [31:0]      fin_value;
        logic [CNT_W-1:0] fin_cursor;
        logic             rd_go;
        logic [POS_W-1:0] rd_cand;
        logic [2:0]       need;
        logic [POS_W-1:0] fill_ext;
        logic [POS_W-1:0] cur_ext;
        logic [POS_W-1:0] nxt;
        logic [31:0]      win;
        logic [2:0]       cnt_up;

        n_state       = r_state;
        n_mode        = r_mode;
        n_tag         = r_tag;
        n_pattern     = r_pattern;
        n_fill        = r_fill;
        n_cursor      = r_cursor;
        n_miss        = r_miss;
        n_pos         = r_pos;
        n_len_hi      = r_len_hi;
        n_cnt         = r_cnt;
        n_acc         = r_acc;
        n_out_valid   = r_out_valid;
        n_out_value   = r_out_value;
        n_out_found   = r_out_found;
        n_out_miss    = r_out_miss;
        n_out_cursor  = r_out_cursor;
        n_out_dropped = r_out_dropped;

        ram_we     = 1'b0;
        rd_addr    = r_pos[ADDR_W-1:0];
        fin        = 1'b0;
        fin_found  = 1'b0;
        fin_miss   = 1'b0;
        fin_drop   = 1'b0;
        fin_value  = '0;
        fin_cursor = r_cursor;
        rd_go      = 1'b0;
        rd_cand    = r_pos;
        need       = (r_mode == MODE_RD16) ? NEED16 : NEED32;
        fill_ext   = POS_W'(r_fill);
        cur_ext    = POS_W'(r_cursor);
        nxt        = r_pos + POS_W'(3) + POS_W'({r_len_hi, ram_q});
        win        = {r_acc[23:0], ram_q};
        cnt_up     = (r_cnt == NEED32) ? NEED32 : r_cnt + 3'd1;

        in_ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
        acc      = i_in.valid && in_ready;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_mode    = i_in.mode;
                    n_tag     = i_in.tag;
                    n_pattern = i_in.fourcc;
                    case (i_in.mode)
                        MODE_LOAD: begin
                            fin = 1'b1;
                            if (r_fill < CNT_W'(BUFFER_BYTES)) begin
                                ram_we = 1'b1;
                                n_fill = r_fill + CNT_W'(1);
                            end else begin
                                fin_drop = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            fin        = 1'b1;
                            n_fill     = '0;
                            n_cursor   = '0;
                            n_miss     = 1'b0;
                            fin_cursor = '0;
                        end
                        MODE_RD16, MODE_RD32, MODE_SKIP: begin
                            if (cur_ext + POS_W'(3) <= fill_ext) begin
                                rd_addr = r_cursor[ADDR_W-1:0];
                                n_pos   = cur_ext;
                                n_state = S_WTAG;
                            end else begin
                                fin      = 1'b1;
                                fin_miss = 1'b1;
                            end
                        end
                        MODE_FOURCC: begin
                            if (r_cursor < r_fill) begin
                                rd_addr = r_cursor[ADDR_W-1:0];
                                n_pos   = cur_ext;
                                n_cnt   = '0;
                                n_state = S_SCAN;
                            end else begin
                                fin      = 1'b1;
                                fin_miss = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_WTAG: begin
                if (ram_q == r_tag) begin
                    if (r_mode == MODE_SKIP) begin
                        fin        = 1'b1;
                        fin_found  = 1'b1;
                        fin_cursor = CNT_W'(r_pos + POS_W'(3));
                    end else begin
                        rd_go   = 1'b1;
                        rd_cand = r_pos + POS_W'(3);
                    end
                end else begin
                    rd_addr = ADDR_W'(r_pos + POS_W'(1));
                    n_state = S_WLEN1;
                end
            end
            S_WLEN1: begin
                n_len_hi = ram_q;
                rd_addr  = ADDR_W'(r_pos + POS_W'(2));
                n_state  = S_WLEN2;
            end
            S_WLEN2: begin
                // next header must fit before the fill mark
                if (nxt + POS_W'(3) <= fill_ext) begin
                    rd_addr = nxt[ADDR_W-1:0];
                    n_pos   = nxt;
                    n_state = S_WTAG;
                end else begin
                    fin      = 1'b1;
                    fin_miss = 1'b1;
                end
            end
            S_SCAN: begin
                n_acc = win;
                n_cnt = cnt_up;
                if (cnt_up == NEED32 && win == r_pattern) begin
                    rd_go   = 1'b1;
                    rd_cand = r_pos + POS_W'(1);
                end else if (r_pos + POS_W'(1) < fill_ext) begin
                    rd_addr = ADDR_W'(r_pos + POS_W'(1));
                    n_pos   = r_pos + POS_W'(1);
                end else begin
                    fin      = 1'b1;
                    fin_miss = 1'b1;
                end
            end
            S_READ: begin
                n_acc   = win;
                n_cnt   = r_cnt + 3'd1;
                rd_addr = ADDR_W'(r_pos + POS_W'(1));
                n_pos   = r_pos + POS_W'(1);
                if (r_cnt + 3'd1 == need) begin
                    fin        = 1'b1;
                    fin_found  = 1'b1;
                    fin_value  = win;
                    fin_cursor = CNT_W'(r_pos + POS_W'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start the value read at the payload, if enough bytes are loaded
        if (rd_go) begin
            if (rd_cand + POS_W'(need) > fill_ext) begin
                fin      = 1'b1;
                fin_miss = 1'b1;
            end else begin
                rd_addr = rd_cand[ADDR_W-1:0];
                n_pos   = rd_cand;
                n_cnt   = '0;
                n_acc   = '0;
                n_state = S_READ;
            end
        end

        if (fin) begin
            n_state = S_IDLE;
            if (fin_miss) begin
                n_miss = 1'b1;
            end
            if (fin_found) begin
                n_cursor = fin_cursor;
            end
            n_out_valid   = 1'b1;
            n_out_value   = fin_value;
            n_out_found   = fin_found;
            n_out_miss    = n_miss;
            n_out_cursor  = fin_cursor;
            n_out_dropped = fin_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_miss      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cursor    <= n_cursor;
            r_miss      <= n_miss;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_tag         <= n_tag;
        r_pattern     <= n_pattern;
        r_pos         <= n_pos;
        r_len_hi      <= n_len_hi;
        r_cnt         <= n_cnt;
        r_acc         <= n_acc;
        r_out_value   <= n_out_value;
        r_out_found   <= n_out_found;
        r_out_miss    <= n_out_miss;
        r_out_cursor  <= n_out_cursor;
        r_out_dropped <= n_out_dropped;
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.found        = r_out_found;
    assign o_out.miss_flag    = r_out_miss;
    assign o_out.cursor_pos   = CUR_W'(r_out_cursor);
    assign o_out.load_dropped = r_out_dropped;

endmodule

// ===== rtl/tsr_ram.sv =====
module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/tsr_checker.sv =====
module tsr_checker import tsr_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [31:0]      i_value,
    input logic             i_found,
    input logic [CUR_W-1:0] i_cursor_pos,
    input logic             i_load_dropped
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value)
                                        && $stable(i_cursor_pos) && $stable(i_found))
        else $error("result changed while stalled");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_cursor_pos) <= 32'(BUFFER_BYTES))
        else $error("cursor beyond buffer");

    a_value_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_value != 32'd0 |-> i_found)
        else $error("nonzero value without a hit");

    a_drop_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_load_dropped |-> !i_found)
        else $error("dropped load reported as hit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind tlv_tag_seek_reader tsr_checker u_tsr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_value        (o_out.value),
    .i_found        (o_out.found),
    .i_cursor_pos   (o_out.cursor_pos),
    .i_load_dropped (o_out.load_dropped)
);

// ===== bench/tlv_tag_seek_reader_test.sv =====
`timescale 1ns / 1ps

module tlv_tag_seek_reader_test;
    import tsr_pkg::*;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [7:0] END_TAG      = 8'hEE;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 50;

    // tag 00 len 2 | tag FF len 4 | tag 7E whose length runs far past the end
    localparam logic [7:0] DEMO_STREAM [15] = '{
        8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF,
        8'hFF, 8'h00, 8'h04, 8'h12, 8'h34, 8'h56, 8'h78,
        8'h7E, 8'hFF, 8'hFF
    };

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  data_byte;
        logic [7:0]  tag;
        logic [31:0] fourcc;
    } t_tlv_item;

    typedef struct packed {
        logic [31:0]      value;
        logic             found;
        logic             miss_flag;
        logic [CUR_W-1:0] cursor_pos;
        logic             load_dropped;
    } t_tlv_answer;

    class tlv_query_checker;
        bit [7:0]    store [BUFFER_BYTES];
        int          fill_level;
        int          read_pos;
        bit          miss_seen;
        t_tlv_answer expected_answers [$];
        int          failures;

        function bit [7:0] byte_at(int pos);
            if (pos >= fill_level) return 8'h00;
            return store[pos];
        endfunction

        function bit [31:0] word_at(int pos, int n);
            bit [31:0] w = '0;
            for (int k = 0; k < n; k++) w = {w[23:0], byte_at(pos + k)};
            return w;
        endfunction

        // hop over entries until the tag matches; land on the payload
        function bit walk_to(bit [7:0] want);
            int pos = read_pos;
            while (pos + 3 <= fill_level) begin
                if (byte_at(pos) == want) begin
                    read_pos = pos + 3;
                    return 1'b1;
                end
                pos += 3 + int'(word_at(pos + 1, 2));
                if (pos > fill_level) break;
            end
            miss_seen = 1'b1;
            return 1'b0;
        endfunction

        function bit scan_for(bit [31:0] pattern);
            for (int i = read_pos; i + 4 <= fill_level; i++) begin
                if (word_at(i, 4) == pattern) begin
                    read_pos = i + 4;
                    return 1'b1;
                end
            end
            miss_seen = 1'b1;
            return 1'b0;
        endfunction

        function void note_item(t_tlv_item it);
            t_tlv_answer a = '0;
            int saved = read_pos;
            int need;
            bit hit;
            case (it.mode)
                MODE_LOAD: begin
                    if (fill_level < BUFFER_BYTES) begin
                        store[fill_level] = it.data_byte;
                        fill_level++;
                    end else begin
                        a.load_dropped = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    fill_level = 0;
                    read_pos   = 0;
                    miss_seen  = 1'b0;
                end
                MODE_RD16, MODE_RD32, MODE_FOURCC: begin
                    need = (it.mode == MODE_RD16) ? int'(NEED16) : int'(NEED32);
                    hit  = (it.mode == MODE_FOURCC) ? scan_for(it.fourcc) : walk_to(it.tag);
                    if (!hit) begin
                        read_pos = saved;
                    end else if (read_pos + need > fill_level) begin
                        miss_seen = 1'b1;
                        read_pos  = saved;
                    end else begin
                        a.value  = word_at(read_pos, need);
                        read_pos += need;
                        a.found  = 1'b1;
                    end
                end
                MODE_SKIP: begin
                    if (walk_to(it.tag)) a.found = 1'b1;
                    else read_pos = saved;
                end
                default: ;
            endcase
            a.miss_flag  = miss_seen;
            a.cursor_pos = read_pos[CUR_W-1:0];
            expected_answers.push_back(a);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
                failures++;
            end
        endfunction

        function void check_result(t_tlv_answer got);
            t_tlv_answer want;
            if (expected_answers.size() == 0) begin
                $display("%0t: result with nothing pending: value %0h cursor %0d",
                         $time, got.value, got.cursor_pos);
                failures++;
                return;
            end
            want = expected_answers.pop_front();
            compare("value", want.value, got.value);
            compare("found", want.found, got.found);
            compare("miss_flag", want.miss_flag, got.miss_flag);
            compare("cursor_pos", want.cursor_pos, got.cursor_pos);
            compare("load_dropped", want.load_dropped, got.load_dropped);
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tsr_in_if  in_ch ();
    tsr_out_if out_ch ();

    tlv_tag_seek_reader DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tlv_query_checker chk = new;

    logic [7:0] image [$];  // bytes loaded since the last clear
    int sent_count;
    int burst_left;
    int hold_asked;
    int hold_done;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            chk.note_item('{in_ch.mode, in_ch.data_byte, in_ch.tag, in_ch.fourcc});
        if (i_rst_n && out_ch.valid && out_ch.ready)
            chk.check_result('{out_ch.value, out_ch.found, out_ch.miss_flag,
                               out_ch.cursor_pos, out_ch.load_dropped});
    end

    function automatic t_tlv_item byte_item(logic [7:0] b);
        return '{MODE_LOAD, b, 8'($urandom), $urandom};
    endfunction

    function automatic t_tlv_item query_item(logic [2:0] m, logic [7:0] t, logic [31:0] p);
        return '{m, 8'($urandom), t, p};
    endfunction

    function automatic logic [31:0] pattern_at(int off);
        return {image[off], image[off + 1], image[off + 2], image[off + 3]};
    endfunction

    // call at a falling edge; returns at the falling edge after the item is taken
    task automatic send(t_tlv_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
            if (gap > 0) begin
                in_ch.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.mode      = it.mode;
        in_ch.data_byte = it.data_byte;
        in_ch.tag       = it.tag;
        in_ch.fourcc    = it.fourcc;
        in_ch.valid     = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
        burst_left--;
        if (it.mode == MODE_LOAD && image.size() < BUFFER_BYTES) image.push_back(it.data_byte);
        if (it.mode == MODE_CLEAR) image.delete();
        if (it.mode <= MODE_SKIP) sent_count++;
    endtask

    task automatic load_entry(logic [7:0] t, logic [15:0] len, int body);
        send(byte_item(t));
        send(byte_item(len[15:8]));
        send(byte_item(len[7:0]));
        repeat (body) send(byte_item(8'($urandom)));
    endtask

    // pack the whole store with entries, ending in an empty END_TAG entry, then overflow and query it
    task automatic fill_to_capacity();
        int room;
        logic [15:0] len;
        send(query_item(MODE_CLEAR, 8'($urandom), $urandom));
        hold_asked++;
        room = BUFFER_BYTES;
        while (room >= 50) begin
            len = 16'($urandom_range(0, 40));
            load_entry(8'($urandom_range(0, END_TAG - 1)), len, len);
            room -= 3 + len;
        end
        load_entry(8'($urandom_range(0, END_TAG - 1)), 16'(room - 6), room - 6);
        load_entry(END_TAG, 16'h0000, 0);
        repeat (3) send(byte_item(8'($urandom)));
        send(query_item(MODE_RD32, END_TAG, $urandom));
        send(query_item(MODE_FOURCC, 8'($urandom), $urandom));
        send(query_item(MODE_SKIP, END_TAG, $urandom));
        send(query_item(MODE_RD16, END_TAG, $urandom));
        send(query_item(MODE_FOURCC, END_TAG, pattern_at(BUFFER_BYTES - 8)));
        send(query_item(MODE_SPARE_7, 8'($urandom), $urandom));
    endtask

    // entries with random content (the last one sometimes broken), then a run of queries over them
    task automatic run_session();
        logic [7:0]  pool [4];
        int          entries;
        int          body;
        int          off;
        logic [15:0] len;
        logic [7:0]  t;
        logic [31:0] p;
        logic [2:0]  m;
        foreach (pool[j]) pool[j] = 8'($urandom);
        if (image.size() > 200 || $urandom_range(0, 3) != 0)
            send(query_item(MODE_CLEAR, 8'($urandom), $urandom));
        entries = $urandom_range(1, 8);
        for (int e = 0; e < entries; e++) begin
            case ($urandom_range(0, 5))
                0: len = 16'(NEED16);
                1: len = 16'(NEED32);
                default: len = 16'($urandom_range(0, 10));
            endcase
            body = len;
            // break the last entry: a wild length with a cut payload
            if (e == entries - 1 && $urandom_range(0, 4) == 0) begin
                len  = 16'($urandom);
                body = $urandom_range(0, 6);
                if (body > len) body = len;
            end
            load_entry(pool[$urandom_range(0, 3)], len, body);
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) send(byte_item(pool[0]));
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 9))
                0, 1:    m = MODE_RD16;
                2, 3:    m = MODE_RD32;
                4, 5, 6: m = MODE_FOURCC;
                7, 8:    m = MODE_SKIP;
                default: m = 3'($urandom);
            endcase
            t = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pool[$urandom_range(0, 3)];
            p = $urandom;
            if (image.size() >= 4 && $urandom_range(0, 3) != 0) begin
                off = $urandom_range(0, image.size() - 4);
                p   = pattern_at(off);
            end
            if (m == MODE_LOAD) send(byte_item(8'($urandom)));
            else send(query_item(m, t, p));
        end
    endtask

    initial begin : result_sink
        int style;
        int tick;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            style = $urandom_range(0, 3);
            repeat ($urandom_range(16, 200)) begin
                @(negedge i_clk);
                tick++;
                if (hold_done != hold_asked) begin
                    hold_done++;
                    out_ch.ready = 1'b0;
                    repeat (HOLDOFF_CYCLES) @(negedge i_clk);
                end
                case (style)
                    0: out_ch.ready = 1'b1;
                    1: out_ch.ready = ($urandom_range(0, 3) != 0);
                    2: out_ch.ready = ($urandom_range(0, 3) == 0);
                    default: out_ch.ready = ((tick % 8) < 3);
                endcase
            end
        end
    end

    initial begin : stimulus
        int start;
        bit pressed;
        logic [2:0] m;
        in_ch.valid     = 1'b0;
        in_ch.mode      = MODE_LOAD;
        in_ch.data_byte = '0;
        in_ch.tag       = '0;
        in_ch.fourcc    = '0;
        i_rst_n         = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty buffer, unused modes, then clear the sticky miss
        send(query_item(MODE_RD16, 8'h00, 32'h0000_0000));
        send(query_item(MODE_FOURCC, 8'hFF, 32'hFFFF_FFFF));
        send(query_item(MODE_SPARE_6, 8'h00, 32'h0000_0000));
        send(query_item(MODE_SPARE_7, 8'hFF, 32'hFFFF_FFFF));
        send(query_item(MODE_CLEAR, 8'h00, 32'h0000_0000));
        foreach (DEMO_STREAM[j]) send(byte_item(DEMO_STREAM[j]));
        send(query_item(MODE_RD16, 8'h55, 32'h0000_0000));     // walk runs past the end
        send(query_item(MODE_RD16, 8'h7E, 32'h0000_0000));     // match with no payload
        send(query_item(MODE_FOURCC, 8'h00, 32'h1234_5678));   // match with no room to read
        send(query_item(MODE_RD16, 8'h00, 32'h0000_0000));
        send(query_item(MODE_RD32, 8'hFF, 32'h0000_0000));
        send(query_item(MODE_SKIP, 8'h7E, 32'h0000_0000));
        send(query_item(MODE_FOURCC, 8'h00, 32'hFFFF_FFFF));

        fill_to_capacity();

        start   = sent_count;
        pressed = 1'b0;
        while (sent_count - start < RANDOM_ITEMS) begin
            if (!pressed && sent_count - start >= RANDOM_ITEMS / 2) begin
                hold_asked++;
                pressed = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(4, 12)) begin
                    m = 3'($urandom);
                    if (m == MODE_LOAD) send(byte_item(8'($urandom)));
                    else send(query_item(m, 8'($urandom), $urandom));
                end
            end else begin
                run_session();
            end
        end
        in_ch.valid = 1'b0;

        while (chk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.failures == 0 && chk.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin : watchdog
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== tlv_tag_seek_reader.f =====
rtl/tsr_pkg.sv
rtl/tsr_if.sv
rtl/tsr_ram.sv
rtl/tlv_tag_seek_reader.sv
rtl/tsr_checker.sv
bench/tlv_tag_seek_reader_test.sv
